@@ src/cppl_pkg.sv @@
package cppl_pkg;

   localparam int COORD_W    = 24;
   localparam int DIFF_W     = 25;
   localparam int MUL_W      = 26;
   localparam int PROD_W     = 52;
   localparam int LEN_W      = 50;
   localparam int DOT_W      = 51;
   localparam int T_W        = 25;
   localparam int TFRAC      = 24;
   localparam int SEG_W      = 25;
   localparam int RUN_W      = 40;
   localparam int D2_W       = 50;
   localparam int LATSQ_W    = 49;
   localparam int LAT_W      = 24;
   localparam int LATR_W     = 26;
   localparam int SQ_IN_W    = 62;
   localparam int SQ_ROOT_W  = 31;
   localparam int SQ_REM_W   = 33;
   localparam int SQ_STEPS   = 31;
   localparam int DV_REM_W   = 50;
   localparam int DV_SH_W    = 45;
   localparam int DV_Q_W     = 25;
   localparam int DV_CNT_W   = 6;
   localparam int T_STEPS    = 24;
   localparam int N_STEPS    = 45;
   localparam int ALONG_W    = 30;
   localparam int NORM_W     = 16;
   localparam int VTX_W      = 72;
   localparam int IDX_W      = 6;
   localparam int COUNT_W    = 7;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 160;

   localparam logic signed [NORM_W-1:0] NORM_ONE = 16'sd16384;
   localparam logic signed [PROD_W-1:0] HALF_T   = 52'sd8388608;

   // datapath operations
   localparam logic [4:0] OP_NOP       = 5'd0;
   localparam logic [4:0] OP_WRITE     = 5'd1;
   localparam logic [4:0] OP_START     = 5'd2;
   localparam logic [4:0] OP_LATCH_A   = 5'd3;
   localparam logic [4:0] OP_LATCH_B   = 5'd4;
   localparam logic [4:0] OP_SAVE_LEN  = 5'd5;
   localparam logic [4:0] OP_SAVE_DOT  = 5'd6;
   localparam logic [4:0] OP_SAVE_SEG  = 5'd7;
   localparam logic [4:0] OP_T_DIV     = 5'd8;
   localparam logic [4:0] OP_SAVE_QX   = 5'd9;
   localparam logic [4:0] OP_SAVE_QY   = 5'd10;
   localparam logic [4:0] OP_SAVE_QZ   = 5'd11;
   localparam logic [4:0] OP_SAVE_CAND = 5'd12;
   localparam logic [4:0] OP_UPDATE    = 5'd13;
   localparam logic [4:0] OP_FIN_D     = 5'd14;
   localparam logic [4:0] OP_LAT_START = 5'd15;
   localparam logic [4:0] OP_LAT_SAVE  = 5'd16;
   localparam logic [4:0] OP_L12_SAVE  = 5'd17;
   localparam logic [4:0] OP_NX_SAVE   = 5'd18;
   localparam logic [4:0] OP_NZ_SAVE   = 5'd19;
   localparam logic [4:0] OP_OUT_LOAD  = 5'd20;

   // multiplier operand selects
   localparam logic [3:0] M_NONE = 4'd0;
   localparam logic [3:0] M_EX2  = 4'd1;
   localparam logic [3:0] M_EY2  = 4'd2;
   localparam logic [3:0] M_EZ2  = 4'd3;
   localparam logic [3:0] M_DOTX = 4'd4;
   localparam logic [3:0] M_DOTY = 4'd5;
   localparam logic [3:0] M_DOTZ = 4'd6;
   localparam logic [3:0] M_EXT  = 4'd7;
   localparam logic [3:0] M_EYT  = 4'd8;
   localparam logic [3:0] M_EZT  = 4'd9;
   localparam logic [3:0] M_TSL  = 4'd10;
   localparam logic [3:0] M_RX2  = 4'd11;
   localparam logic [3:0] M_RY2  = 4'd12;
   localparam logic [3:0] M_RZ2  = 4'd13;
   localparam logic [3:0] M_DX2  = 4'd14;
   localparam logic [3:0] M_DZ2  = 4'd15;

   // accumulator modes
   localparam logic [1:0] ACC_HOLD = 2'd0;
   localparam logic [1:0] ACC_LOAD = 2'd1;
   localparam logic [1:0] ACC_ADD  = 2'd2;

   typedef struct packed {
      logic [4:0] op;
      logic [3:0] msel;
      logic [1:0] acc;
   } cppl_cmd_type;

   typedef struct packed {
      logic len_zero;
      logic t_div;
      logic lat_zero;
      logic sq_busy;
      logic dv_busy;
   } cppl_status_type;

endpackage

@@ src/cppl_ram.sv @@
module cppl_ram #(
   parameter int WIDTH = 72,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/cppl_dp.sv @@
module cppl_dp #(
   parameter int MAX_VERTICES = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cppl_pkg::cppl_cmd_type               cmd,
   input  logic [$clog2(MAX_VERTICES)-1:0]      rd_addr,
   input  logic [cppl_pkg::REQ_DATA_W-1:0]      req_data,
   output cppl_pkg::cppl_status_type            status,
   output logic [cppl_pkg::RSP_DATA_W-1:0]      rsp_data
);
   import cppl_pkg::*;

   localparam int AW = $clog2(MAX_VERTICES);

   function automatic logic signed [DIFF_W-1:0] sub24(input logic [COORD_W-1:0] a,
                                                      input logic [COORD_W-1:0] b);
      sub24 = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
   endfunction

   function automatic logic signed [MUL_W-1:0] ext(input logic [DIFF_W-1:0] v);
      ext = $signed({v[DIFF_W-1], v});
   endfunction

   // request fields
   logic [IDX_W-1:0]       in_idx;
   logic [COORD_W-1:0]     in_x, in_y, in_z;
   logic [AW+IDX_W-1:0]    idx_wide;
   logic                   wr_en;
   logic [VTX_W-1:0]       ram_q;

   assign in_idx   = req_data[5:0];
   assign in_x     = req_data[29:6];
   assign in_y     = req_data[53:30];
   assign in_z     = req_data[77:54];
   assign idx_wide = {AW'(0), in_idx};
   assign wr_en    = (cmd.op == OP_WRITE) && (32'(in_idx) < MAX_VERTICES);

   cppl_ram #(.WIDTH(VTX_W), .DEPTH(MAX_VERTICES)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_wide[AW-1:0]),
      .wr_data ({in_z, in_y, in_x}),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // segment and query registers
   logic [COORD_W-1:0]        px_ff, py_ff, pz_ff;
   logic [COORD_W-1:0]        ax_ff, ay_ff, az_ff;
   logic signed [DIFF_W-1:0]  ex_ff, ey_ff, ez_ff;
   logic [COORD_W-1:0]        qx_ff, qy_ff, qz_ff;
   logic [COORD_W-1:0]        cx_ff, cy_ff, cz_ff;
   logic signed [DIFF_W-1:0]  dx_ff, dz_ff;
   logic [LEN_W-1:0]          lensq_ff;
   logic signed [DOT_W-1:0]   dot_ff;
   logic [SEG_W-1:0]          seglen_ff;
   logic [T_W-1:0]            t_ff;
   logic [RUN_W-1:0]          running_ff, cand_ff, along_ff;
   logic [D2_W-1:0]           best_ff;
   logic                      found_ff;
   logic [LATSQ_W-1:0]        latsq_ff;
   logic [LATR_W-1:0]         lat_ff;
   logic [SQ_ROOT_W-1:0]      l12_ff;
   logic [NORM_W-1:0]         nx_ff, nz_ff;
   logic [RSP_DATA_W-1:0]     rsp_data_ff;

   // shared multiplier and accumulator
   logic signed [MUL_W-1:0]   ma, mb;
   logic signed [PROD_W-1:0]  prod_in, prod_ff, acc_ff, prod_rnd;

   always_comb begin
      ma = '0;
      mb = '0;
      case (cmd.msel)
         M_EX2:  begin ma = ext(ex_ff); mb = ext(ex_ff); end
         M_EY2:  begin ma = ext(ey_ff); mb = ext(ey_ff); end
         M_EZ2:  begin ma = ext(ez_ff); mb = ext(ez_ff); end
         M_DOTX: begin ma = ext(sub24(px_ff, ax_ff)); mb = ext(ex_ff); end
         M_DOTY: begin ma = ext(sub24(py_ff, ay_ff)); mb = ext(ey_ff); end
         M_DOTZ: begin ma = ext(sub24(pz_ff, az_ff)); mb = ext(ez_ff); end
         M_EXT:  begin ma = ext(ex_ff); mb = $signed({1'b0, t_ff}); end
         M_EYT:  begin ma = ext(ey_ff); mb = $signed({1'b0, t_ff}); end
         M_EZT:  begin ma = ext(ez_ff); mb = $signed({1'b0, t_ff}); end
         M_TSL:  begin ma = $signed({1'b0, t_ff}); mb = $signed({1'b0, seglen_ff}); end
         M_RX2:  begin ma = ext(sub24(px_ff, qx_ff)); mb = ext(sub24(px_ff, qx_ff)); end
         M_RY2:  begin ma = ext(sub24(py_ff, qy_ff)); mb = ext(sub24(py_ff, qy_ff)); end
         M_RZ2:  begin ma = ext(sub24(pz_ff, qz_ff)); mb = ext(sub24(pz_ff, qz_ff)); end
         M_DX2:  begin ma = ext(dx_ff); mb = ext(dx_ff); end
         M_DZ2:  begin ma = ext(dz_ff); mb = ext(dz_ff); end
         default: begin ma = '0; mb = '0; end
      endcase
   end

   assign prod_in  = ma * mb;
   assign prod_rnd = prod_ff + HALF_T;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      case (cmd.acc)
         ACC_LOAD: acc_ff <= prod_ff;
         ACC_ADD:  acc_ff <= acc_ff + prod_ff;
         default:  acc_ff <= acc_ff;
      endcase
   end

   // square root unit, one root bit per cycle
   logic                     sq_busy_ff, sq_start;
   logic [SQ_IN_W-1:0]       sq_val_ff, sq_val_in;
   logic [SQ_REM_W-1:0]      sq_rem_ff;
   logic [SQ_ROOT_W-1:0]     sq_root_ff;
   logic [4:0]               sq_cnt_ff;
   logic [SQ_REM_W+1:0]      sq_rem_sh, sq_trial, sq_diff;
   logic                     sq_ge, sq_round;

   assign sq_start  = ((cmd.op == OP_SAVE_DOT) && (lensq_ff != '0)) ||
                      (cmd.op == OP_LAT_START) || (cmd.op == OP_LAT_SAVE);
   assign sq_rem_sh = {sq_rem_ff, sq_val_ff[SQ_IN_W-1 -: 2]};
   assign sq_trial  = {2'b00, sq_root_ff, 2'b01};
   assign sq_diff   = sq_rem_sh - sq_trial;
   assign sq_ge     = sq_rem_sh >= sq_trial;
   assign sq_round  = sq_rem_ff > {2'b00, sq_root_ff};

   always_comb begin
      case (cmd.op)
         OP_SAVE_DOT:  sq_val_in = SQ_IN_W'(lensq_ff);
         OP_LAT_START: sq_val_in = SQ_IN_W'(acc_ff[LATSQ_W-1:0]);
         default:      sq_val_in = {1'b0, latsq_ff, 12'b0};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_busy_ff <= 1'b0;
      end else if (sq_start) begin
         sq_busy_ff <= 1'b1;
      end else if (sq_busy_ff && (sq_cnt_ff == 5'd1)) begin
         sq_busy_ff <= 1'b0;
      end
      if (sq_start) begin
         sq_val_ff  <= sq_val_in;
         sq_rem_ff  <= '0;
         sq_root_ff <= '0;
         sq_cnt_ff  <= 5'(SQ_STEPS);
      end else if (sq_busy_ff) begin
         sq_val_ff  <= {sq_val_ff[SQ_IN_W-3:0], 2'b00};
         sq_rem_ff  <= sq_ge ? sq_diff[SQ_REM_W-1:0] : sq_rem_sh[SQ_REM_W-1:0];
         sq_root_ff <= {sq_root_ff[SQ_ROOT_W-2:0], sq_ge};
         sq_cnt_ff  <= sq_cnt_ff - 5'd1;
      end
   end

   // restoring divider, one quotient bit per cycle
   logic                     dv_busy_ff, dv_start;
   logic [DV_REM_W-1:0]      dv_rem_ff, dv_rem_in, dv_den_ff, dv_den_in;
   logic [DV_SH_W-1:0]       dv_sh_ff, dv_sh_in;
   logic [DV_Q_W-1:0]        dv_q_ff;
   logic [DV_CNT_W-1:0]      dv_cnt_ff, dv_cnt_in;
   logic [DV_REM_W:0]        dv_rem_sh, dv_diff;
   logic                     dv_ge;
   logic signed [DIFF_W-1:0] nsrc;
   logic [DIFF_W-1:0]        nmag;
   logic                     dot_pos, dot_ge, t_div;

   assign dot_pos = !dot_ff[DOT_W-1] && (dot_ff != '0);
   assign dot_ge  = dot_ff >= $signed({1'b0, lensq_ff});
   assign t_div   = dot_pos && !dot_ge;

   assign nsrc = (cmd.op == OP_NX_SAVE) ? dz_ff : dx_ff;
   assign nmag = nsrc[DIFF_W-1] ? DIFF_W'(-nsrc) : DIFF_W'(nsrc);

   assign dv_start  = ((cmd.op == OP_SAVE_SEG) && t_div) ||
                      ((cmd.op == OP_L12_SAVE) && (latsq_ff != '0)) ||
                      (cmd.op == OP_NX_SAVE);
   assign dv_rem_sh = {dv_rem_ff, dv_sh_ff[DV_SH_W-1]};
   assign dv_diff   = dv_rem_sh - {1'b0, dv_den_ff};
   assign dv_ge     = dv_rem_sh >= {1'b0, dv_den_ff};

   always_comb begin
      if (cmd.op == OP_SAVE_SEG) begin
         dv_rem_in = dot_ff[DV_REM_W-1:0];
         dv_sh_in  = '0;
         dv_den_in = lensq_ff;
         dv_cnt_in = DV_CNT_W'(T_STEPS);
      end else begin
         dv_rem_in = '0;
         dv_sh_in  = DV_SH_W'({nmag[COORD_W-1:0], 20'b0}) +
                     DV_SH_W'(((cmd.op == OP_L12_SAVE) ? sq_root_ff : l12_ff) >> 1);
         dv_den_in = DV_REM_W'((cmd.op == OP_L12_SAVE) ? sq_root_ff : l12_ff);
         dv_cnt_in = DV_CNT_W'(N_STEPS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_busy_ff <= 1'b0;
      end else if (dv_start) begin
         dv_busy_ff <= 1'b1;
      end else if (dv_busy_ff && (dv_cnt_ff == DV_CNT_W'(1))) begin
         dv_busy_ff <= 1'b0;
      end
      if (dv_start) begin
         dv_rem_ff <= dv_rem_in;
         dv_sh_ff  <= dv_sh_in;
         dv_den_ff <= dv_den_in;
         dv_q_ff   <= '0;
         dv_cnt_ff <= dv_cnt_in;
      end else if (dv_busy_ff) begin
         dv_rem_ff <= dv_ge ? dv_diff[DV_REM_W-1:0] : dv_rem_sh[DV_REM_W-1:0];
         dv_sh_ff  <= {dv_sh_ff[DV_SH_W-2:0], 1'b0};
         dv_q_ff   <= {dv_q_ff[DV_Q_W-2:0], dv_ge};
         dv_cnt_ff <= dv_cnt_ff - DV_CNT_W'(1);
      end
   end

   // operation decode
   logic [D2_W-1:0]         d2;
   logic [NORM_W-1:0]       q16;
   logic [ALONG_W-1:0]      along_sat;
   logic [LAT_W-1:0]        lat_sat;

   assign d2        = acc_ff[D2_W-1:0];
   assign q16       = dv_q_ff[NORM_W-1:0];
   assign along_sat = (along_ff[RUN_W-1:ALONG_W] != '0) ? '1 : along_ff[ALONG_W-1:0];
   assign lat_sat   = (lat_ff[LATR_W-1:LAT_W] != '0) ? '1 : lat_ff[LAT_W-1:0];

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_START: begin
            px_ff      <= in_x;
            py_ff      <= in_y;
            pz_ff      <= in_z;
            running_ff <= '0;
            along_ff   <= '0;
            found_ff   <= 1'b0;
            cx_ff      <= '0;
            cy_ff      <= '0;
            cz_ff      <= '0;
         end
         OP_LATCH_A: begin
            ax_ff <= ram_q[23:0];
            ay_ff <= ram_q[47:24];
            az_ff <= ram_q[71:48];
         end
         OP_LATCH_B: begin
            ex_ff <= sub24(ram_q[23:0], ax_ff);
            ey_ff <= sub24(ram_q[47:24], ay_ff);
            ez_ff <= sub24(ram_q[71:48], az_ff);
         end
         OP_SAVE_LEN: lensq_ff <= acc_ff[LEN_W-1:0];
         OP_SAVE_DOT: dot_ff   <= acc_ff[DOT_W-1:0];
         OP_SAVE_SEG: begin
            seglen_ff <= SEG_W'(sq_root_ff) + SEG_W'(sq_round);
            if (!dot_pos) begin
               t_ff <= '0;
            end else if (dot_ge) begin
               t_ff <= T_W'(1) << TFRAC;
            end
         end
         OP_T_DIV: t_ff <= dv_q_ff + T_W'({dv_rem_ff, 1'b0} >= {1'b0, lensq_ff});
         OP_SAVE_QX: qx_ff <= ax_ff + prod_rnd[TFRAC +: COORD_W];
         OP_SAVE_QY: qy_ff <= ay_ff + prod_rnd[TFRAC +: COORD_W];
         OP_SAVE_QZ: qz_ff <= az_ff + prod_rnd[TFRAC +: COORD_W];
         OP_SAVE_CAND: cand_ff <= running_ff + RUN_W'(prod_rnd[PROD_W-1:TFRAC]);
         OP_UPDATE: begin
            if (!found_ff || (d2 < best_ff)) begin
               found_ff <= 1'b1;
               best_ff  <= d2;
               along_ff <= cand_ff;
               cx_ff    <= qx_ff;
               cy_ff    <= qy_ff;
               cz_ff    <= qz_ff;
            end
            running_ff <= running_ff + RUN_W'(seglen_ff);
         end
         OP_FIN_D: begin
            dx_ff <= sub24(px_ff, cx_ff);
            dz_ff <= sub24(pz_ff, cz_ff);
         end
         OP_LAT_START: latsq_ff <= acc_ff[LATSQ_W-1:0];
         OP_LAT_SAVE:  lat_ff   <= LATR_W'(sq_root_ff) + LATR_W'(sq_round);
         OP_L12_SAVE: begin
            l12_ff <= sq_root_ff;
            if (latsq_ff == '0) begin
               nx_ff <= '0;
               nz_ff <= NORM_ONE;
            end
         end
         OP_NX_SAVE: nx_ff <= dx_ff[DIFF_W-1] ? -q16 : q16;
         OP_NZ_SAVE: nz_ff <= dz_ff[DIFF_W-1] ? -q16 : q16;
         OP_OUT_LOAD: rsp_data_ff <= {2'b00, nz_ff, nx_ff, lat_sat,
                                      cz_ff, cy_ff, cx_ff, along_sat};
         default: begin
         end
      endcase
   end

   assign status.len_zero = (lensq_ff == '0);
   assign status.t_div    = t_div;
   assign status.lat_zero = (latsq_ff == '0);
   assign status.sq_busy  = sq_busy_ff;
   assign status.dv_busy  = dv_busy_ff;
   assign rsp_data        = rsp_data_ff;

endmodule

@@ src/cppl_ctrl.sv @@
module cppl_ctrl #(
   parameter int MAX_VERTICES = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic                                req_mode,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_wr_en,
   input  logic [cppl_pkg::COUNT_W-1:0]        csr_wr_data,
   input  cppl_pkg::cppl_status_type           status,
   output cppl_pkg::cppl_cmd_type              cmd,
   output logic [$clog2(MAX_VERTICES)-1:0]     rd_addr
);
   import cppl_pkg::*;

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);

   localparam logic [5:0] S_IDLE = 6'd0;
   localparam logic [5:0] S_RDA  = 6'd1;
   localparam logic [5:0] S_RDB  = 6'd2;
   localparam logic [5:0] S_LATB = 6'd3;
   localparam logic [5:0] S_M1   = 6'd4;
   localparam logic [5:0] S_M2   = 6'd5;
   localparam logic [5:0] S_M3   = 6'd6;
   localparam logic [5:0] S_M4   = 6'd7;
   localparam logic [5:0] S_M5   = 6'd8;
   localparam logic [5:0] S_M6   = 6'd9;
   localparam logic [5:0] S_M7   = 6'd10;
   localparam logic [5:0] S_SDOT = 6'd11;
   localparam logic [5:0] S_WSQ  = 6'd12;
   localparam logic [5:0] S_WDIV = 6'd13;
   localparam logic [5:0] S_MQX  = 6'd14;
   localparam logic [5:0] S_MQY  = 6'd15;
   localparam logic [5:0] S_MQZ  = 6'd16;
   localparam logic [5:0] S_MSL  = 6'd17;
   localparam logic [5:0] S_MR1  = 6'd18;
   localparam logic [5:0] S_MR2  = 6'd19;
   localparam logic [5:0] S_MR3  = 6'd20;
   localparam logic [5:0] S_MR4  = 6'd21;
   localparam logic [5:0] S_UPD  = 6'd22;
   localparam logic [5:0] S_NEXT = 6'd23;
   localparam logic [5:0] S_FIN  = 6'd24;
   localparam logic [5:0] S_F1   = 6'd25;
   localparam logic [5:0] S_F2   = 6'd26;
   localparam logic [5:0] S_F3   = 6'd27;
   localparam logic [5:0] S_F4   = 6'd28;
   localparam logic [5:0] S_WLAT = 6'd29;
   localparam logic [5:0] S_WL12 = 6'd30;
   localparam logic [5:0] S_WNX  = 6'd31;
   localparam logic [5:0] S_WNZ  = 6'd32;
   localparam logic [5:0] S_OUT  = 6'd33;

   logic [5:0]         state_ff, state_in;
   logic [AW-1:0]      seg_ff, seg_in;
   logic [CW-1:0]      n_ff, n_in, n_eff;
   logic [COUNT_W-1:0] count_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               last;

   assign n_eff = (32'(count_ff) > MAX_VERTICES) ? CW'(MAX_VERTICES) : CW'(count_ff);
   assign last  = (CW'(seg_ff) == (n_ff - CW'(1)));

   always_comb begin
      state_in     = state_ff;
      seg_in       = seg_ff;
      n_in         = n_ff;
      cmd.op       = OP_NOP;
      cmd.msel     = M_NONE;
      cmd.acc      = ACC_HOLD;
      rd_addr      = seg_ff;
      req_tready   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op = req_mode ? OP_START : OP_WRITE;
               // a loop of fewer than two vertices gives no result
               if (req_mode && (n_eff >= CW'(2))) begin
                  n_in     = n_eff;
                  seg_in   = '0;
                  state_in = S_RDA;
               end
            end
         end
         S_RDA:  state_in = S_RDB;
         S_RDB: begin
            rd_addr  = last ? '0 : seg_ff + AW'(1);
            cmd.op   = OP_LATCH_A;
            state_in = S_LATB;
         end
         S_LATB: begin cmd.op = OP_LATCH_B; state_in = S_M1; end
         S_M1: begin cmd.msel = M_EX2; state_in = S_M2; end
         S_M2: begin cmd.msel = M_EY2; cmd.acc = ACC_LOAD; state_in = S_M3; end
         S_M3: begin cmd.msel = M_EZ2; cmd.acc = ACC_ADD; state_in = S_M4; end
         S_M4: begin cmd.msel = M_DOTX; cmd.acc = ACC_ADD; state_in = S_M5; end
         S_M5: begin
            cmd.msel = M_DOTY;
            cmd.op   = OP_SAVE_LEN;
            cmd.acc  = ACC_LOAD;
            state_in = S_M6;
         end
         S_M6: begin cmd.msel = M_DOTZ; cmd.acc = ACC_ADD; state_in = S_M7; end
         S_M7: begin cmd.acc = ACC_ADD; state_in = S_SDOT; end
         S_SDOT: begin
            cmd.op = OP_SAVE_DOT;
            // drop zero-length segments
            state_in = status.len_zero ? S_NEXT : S_WSQ;
         end
         S_WSQ: begin
            if (!status.sq_busy) begin
               cmd.op   = OP_SAVE_SEG;
               state_in = status.t_div ? S_WDIV : S_MQX;
            end
         end
         S_WDIV: begin
            if (!status.dv_busy) begin
               cmd.op   = OP_T_DIV;
               state_in = S_MQX;
            end
         end
         S_MQX: begin cmd.msel = M_EXT; state_in = S_MQY; end
         S_MQY: begin cmd.msel = M_EYT; cmd.op = OP_SAVE_QX; state_in = S_MQZ; end
         S_MQZ: begin cmd.msel = M_EZT; cmd.op = OP_SAVE_QY; state_in = S_MSL; end
         S_MSL: begin cmd.msel = M_TSL; cmd.op = OP_SAVE_QZ; state_in = S_MR1; end
         S_MR1: begin cmd.msel = M_RX2; cmd.op = OP_SAVE_CAND; state_in = S_MR2; end
         S_MR2: begin cmd.msel = M_RY2; cmd.acc = ACC_LOAD; state_in = S_MR3; end
         S_MR3: begin cmd.msel = M_RZ2; cmd.acc = ACC_ADD; state_in = S_MR4; end
         S_MR4: begin cmd.acc = ACC_ADD; state_in = S_UPD; end
         S_UPD: begin cmd.op = OP_UPDATE; state_in = S_NEXT; end
         S_NEXT: begin
            if (last) begin
               state_in = S_FIN;
            end else begin
               seg_in   = seg_ff + AW'(1);
               state_in = S_RDA;
            end
         end
         S_FIN: begin cmd.op = OP_FIN_D; state_in = S_F1; end
         S_F1: begin cmd.msel = M_DX2; state_in = S_F2; end
         S_F2: begin cmd.msel = M_DZ2; cmd.acc = ACC_LOAD; state_in = S_F3; end
         S_F3: begin cmd.acc = ACC_ADD; state_in = S_F4; end
         S_F4: begin cmd.op = OP_LAT_START; state_in = S_WLAT; end
         S_WLAT: begin
            if (!status.sq_busy) begin
               cmd.op   = OP_LAT_SAVE;
               state_in = S_WL12;
            end
         end
         S_WL12: begin
            if (!status.sq_busy) begin
               cmd.op   = OP_L12_SAVE;
               state_in = status.lat_zero ? S_OUT : S_WNX;
            end
         end
         S_WNX: begin
            if (!status.dv_busy) begin
               cmd.op   = OP_NX_SAVE;
               state_in = S_WNZ;
            end
         end
         S_WNZ: begin
            if (!status.dv_busy) begin
               cmd.op   = OP_NZ_SAVE;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.op   = OP_OUT_LOAD;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.op == OP_OUT_LOAD) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         seg_ff       <= '0;
         n_ff         <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seg_ff       <= seg_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

@@ src/closest_point_on_closed_polyline_unit.sv @@
// Nearest point on a closed loop of 3D vertices (Q15.8). A beat with tuser low
// stores one vertex. A beat with tuser high walks every segment of the loop,
// including the closing one, and returns one result beat: arc length, nearest
// point, XZ lateral distance and XZ unit normal; with fewer than two vertices
// in use it returns nothing. Per segment the time is set by the shared
// square-root unit (one root bit per cycle) and the shared restoring divider,
// which gives the projection parameter; the finish runs two square roots and
// two divides for the normal. One multiplier is shared by all products. A
// finished result waits in an output register, so the next beat is taken
// while it is still pending.
module closest_point_on_closed_polyline_unit #(
   parameter int MAX_VERTICES = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // vertex_index, coord_x, coord_y, coord_z
   input  logic [cppl_pkg::REQ_DATA_W-1:0]   req_tdata,
   // mode
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // distance_along, closest_x, closest_y, closest_z, lateral_distance,
   // normal_x, normal_z
   output logic [cppl_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_wr_en,
   input  logic [cppl_pkg::COUNT_W-1:0]      csr_wr_data
);
   import cppl_pkg::*;

   cppl_cmd_type                     cmd;
   cppl_status_type                  status;
   logic [$clog2(MAX_VERTICES)-1:0]  rd_addr;

   cppl_ctrl #(.MAX_VERTICES(MAX_VERTICES)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_mode    (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .status      (status),
      .cmd         (cmd),
      .rd_addr     (rd_addr)
   );

   cppl_dp #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .rd_addr  (rd_addr),
      .req_data (req_tdata),
      .status   (status),
      .rsp_data (rsp_tdata)
   );

   a_idle_units_quiet: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !(status.sq_busy || status.dv_busy))
      else $error("iterative unit busy while accepting beats");

   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      status.sq_busy |-> !status.dv_busy)
      else $error("square root and divider running together");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_OUT_LOAD) |=> rsp_tvalid)
      else $error("result loaded without valid");

endmodule
